>>> design/dtt_pkg.sv
// shared types, codes and helpers for the deadline timer table
package dtt_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = 6;
  localparam logic [31:0] WINDOW_RESET = 32'd3600000;
  localparam logic [47:0] ALL_ONES48   = '1;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_CANCEL  = 3'd1;
  localparam logic [2:0] OP_REFRESH = 3'd2;
  localparam logic [2:0] OP_RESET   = 3'd3;
  localparam logic [2:0] OP_QUERY   = 3'd4;
  localparam logic [2:0] OP_EXPIRE  = 3'd5;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [2:0] {
    CC_NONE, CC_ADD, CC_CANCEL, CC_SETDL, CC_SETDLPER, CC_MARK, CC_EXPIRE
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   idx;
    logic [47:0]        dl;
    logic [31:0]        per;
    logic               rec;
    logic               jump;
    logic [47:0]        now;
  } cell_cmd_t;

  typedef struct packed {
    logic             go;
    logic             use_due;
    logic             found;
    logic [47:0]      dl;
    logic [IDX_W-1:0] idx;
  } scan_t;

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[48] ? ALL_ONES48 : s[47:0];
  endfunction

endpackage

>>> design/dtt_if.sv
// request and result channel interfaces
interface dtt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [47:0] now_ms;
  logic [3:0]  slot;
  logic [31:0] period_ms;
  logic        recurring;
  logic        restart_now;
  modport source (output valid, operation, now_ms, slot, period_ms, recurring, restart_now,
                  input ready);
  modport sink (input valid, operation, now_ms, slot, period_ms, recurring, restart_now,
                output ready);
endinterface

interface dtt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  slot_out;
  logic [47:0] remaining_ms;
  logic        front_notice;
  logic        any_pending;
  logic        last;
  modport source (output valid, status, slot_out, remaining_ms, front_notice, any_pending,
                  last, input ready);
  modport sink (input valid, status, slot_out, remaining_ms, front_notice, any_pending,
                last, output ready);
endinterface

>>> design/dtt_cell.sv
// one timer slot with its stage of the earliest-deadline scan chain
module dtt_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dtt_pkg::cell_cmd_t cmd,
  input  dtt_pkg::scan_t    tok_in,
  output dtt_pkg::scan_t    tok_out,
  output logic              active,
  output logic [47:0]       deadline,
  output logic [31:0]       period
);
  import dtt_pkg::*;

  logic        active_r, active_nxt;
  logic        due_r, due_nxt;
  logic        rec_r, rec_nxt;
  logic [47:0] dl_r, dl_nxt;
  logic [31:0] per_r, per_nxt;
  scan_t       tok_r, tok_nxt;
  logic        hit, cand;

  assign hit  = (cmd.idx == IDX_W'(IDX));
  assign cand = active_r && (!tok_in.use_due || due_r);

  always_comb begin
    active_nxt = active_r;
    due_nxt    = due_r;
    rec_nxt    = rec_r;
    dl_nxt     = dl_r;
    per_nxt    = per_r;
    case (cmd.op)
      CC_ADD: if (hit) begin
        active_nxt = 1'b1;
        dl_nxt     = cmd.dl;
        per_nxt    = cmd.per;
        rec_nxt    = cmd.rec;
      end
      CC_CANCEL: if (hit) active_nxt = 1'b0;
      CC_SETDL: if (hit) dl_nxt = cmd.dl;
      CC_SETDLPER: if (hit) begin
        dl_nxt  = cmd.dl;
        per_nxt = cmd.per;
      end
      CC_MARK: due_nxt = active_r && (cmd.jump || dl_r <= cmd.now);
      CC_EXPIRE: if (hit) begin
        due_nxt = 1'b0;
        if (rec_r) dl_nxt = cmd.dl;
        else active_nxt = 1'b0;
      end
      default: ;
    endcase
    // earlier deadline wins, ties stay with the lower slot upstream
    tok_nxt = tok_in;
    if (tok_in.go && cand && (!tok_in.found || dl_r < tok_in.dl)) begin
      tok_nxt.found = 1'b1;
      tok_nxt.dl    = dl_r;
      tok_nxt.idx   = IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      due_r    <= 1'b0;
      tok_r    <= '0;
    end else begin
      active_r <= active_nxt;
      due_r    <= due_nxt;
      tok_r    <= tok_nxt;
    end
    rec_r <= rec_nxt;
    dl_r  <= dl_nxt;
    per_r <= per_nxt;
  end

  assign tok_out  = tok_r;
  assign active   = active_r;
  assign deadline = dl_r;
  assign period   = per_r;
endmodule

>>> design/deadline_timer_table_core.sv
// deadline timer table top level: control sequencer over a chain of slot cells
// sequencing: cancel and refresh update the slot from idle, reset adds the S_RST2 step, add and
// query send one scan wave through the cell chain, one cell per cycle; expire first marks
// the due slots, then runs one scan wave per expired slot, then emits one result per slot
// throughput: one transaction in flight at a time, limited by the scan chain length
// reset (synchronous): active marks, notice, previous time cleared, window 3600000
module deadline_timer_table_core #(
  parameter int SLOTS = dtt_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  dtt_in_if.sink      in_ch,
  dtt_out_if.source   out_ch
);
  import dtt_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(MAX_RESULTS + 1);
  localparam int EW = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_XMARK, S_LAUNCH, S_WAIT, S_RST2, S_EMIT, S_XEMIT
  } state_t;

  // chain wiring
  cell_cmd_t   cmd;
  scan_t       tok [SLOTS+1];
  logic        act_w [SLOTS];
  logic [47:0] dl_w  [SLOTS];
  logic [31:0] per_w [SLOTS];

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    dtt_cell #(.IDX(g)) u_cell (
      .clk, .rst_n, .cmd,
      .tok_in(tok[g]), .tok_out(tok[g+1]),
      .active(act_w[g]), .deadline(dl_w[g]), .period(per_w[g])
    );
  end

  state_t state_r, state_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [47:0] now_r, now_nxt;
  logic [31:0] per_r, per_nxt;
  logic        rec_r, rec_nxt;
  logic [IDX_W-1:0] n_r, n_nxt;
  logic [47:0] dl_r, dl_nxt;
  logic        jump_r, jump_nxt;
  logic        notice_r, notice_nxt;
  logic [47:0] prev_r, prev_nxt;
  logic [31:0] win_r, win_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [EW-1:0] e_r, e_nxt;
  logic [IDX_W-1:0] list_r [MAX_RESULTS];
  logic [IDX_W-1:0] list_nxt [MAX_RESULTS];
  // pending result fields
  logic [1:0]  rs_r, rs_nxt;
  logic [3:0]  rslot_r, rslot_nxt;
  logic [47:0] rrem_r, rrem_nxt;
  logic        rfront_r, rfront_nxt;
  // output register
  logic        ov_r, ov_nxt;
  logic [1:0]  os_r, os_nxt;
  logic [3:0]  oslot_r, oslot_nxt;
  logic [47:0] orem_r, orem_nxt;
  logic        ofront_r, ofront_nxt;
  logic        opend_r, opend_nxt;
  logic        olast_r, olast_nxt;

  logic             any_act, full;
  logic [IDX_W-1:0] free_idx;
  logic [SW-1:0]    sidx;
  logic             in_range, slot_ok;
  logic             out_free, accept;
  logic [47:0]      start;
  scan_t            res;
  logic             front;

  always_comb begin
    any_act  = 1'b0;
    full     = 1'b1;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      any_act = any_act | act_w[i];
      full    = full & act_w[i];
      if (!act_w[i]) free_idx = IDX_W'(i);
    end
  end

  assign out_free = !ov_r || out_ch.ready;
  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign res      = tok[SLOTS];
  assign sidx     = SW'(in_ch.slot);
  assign in_range = ({3'b0, in_ch.slot} < 7'(SLOTS));
  assign slot_ok  = in_range && act_w[sidx];
  // start from now_ms when restart_now is set, else from the deadline minus the period, floored at zero
  assign start    = in_ch.restart_now ? in_ch.now_ms :
                    (dl_w[sidx] > {16'b0, per_w[sidx]}) ?
                    dl_w[sidx] - {16'b0, per_w[sidx]} : 48'd0;
  assign front    = !res.found || (res.dl > dl_r) || (res.dl == dl_r && res.idx > n_r);

  // launch token enters the first cell
  always_comb begin
    tok[0]         = '0;
    tok[0].go      = (state_r == S_LAUNCH);
    tok[0].use_due = (op_r == OP_EXPIRE);
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r; now_nxt = now_r; per_nxt = per_r; rec_nxt = rec_r;
    n_nxt = n_r; dl_nxt = dl_r; jump_nxt = jump_r;
    notice_nxt = notice_r; prev_nxt = prev_r;
    win_nxt = cfg_we ? cfg_wdata : win_r;
    cnt_nxt = cnt_r; e_nxt = e_r; list_nxt = list_r;
    rs_nxt = rs_r; rslot_nxt = rslot_r; rrem_nxt = rrem_r; rfront_nxt = rfront_r;
    ov_nxt = ov_r && !out_ch.ready;
    os_nxt = os_r; oslot_nxt = oslot_r; orem_nxt = orem_r;
    ofront_nxt = ofront_r; opend_nxt = opend_r; olast_nxt = olast_r;
    cmd = '0;
    cmd.op = CC_NONE;

    case (state_r)
      S_IDLE: if (accept) begin
        op_nxt  = in_ch.operation;
        now_nxt = in_ch.now_ms;
        per_nxt = in_ch.period_ms;
        rec_nxt = in_ch.recurring;
        rs_nxt = ST_DONE; rslot_nxt = '0; rrem_nxt = '0; rfront_nxt = 1'b0;
        state_nxt = S_EMIT;
        case (in_ch.operation)
          OP_ADD: begin
            if (full) rs_nxt = ST_FULL;
            else begin
              n_nxt  = free_idx;
              dl_nxt = sat_add48(in_ch.now_ms, in_ch.period_ms);
              state_nxt = S_LAUNCH;
            end
          end
          OP_CANCEL, OP_REFRESH, OP_RESET: begin
            if (!slot_ok) rs_nxt = ST_REJECT;
            else if (in_ch.operation == OP_CANCEL) begin
              cmd.op  = CC_CANCEL;
              cmd.idx = IDX_W'(sidx);
            end else if (in_ch.operation == OP_REFRESH) begin
              cmd.op  = CC_SETDL;
              cmd.idx = IDX_W'(sidx);
              cmd.dl  = sat_add48(in_ch.now_ms, per_w[sidx]);
            end else begin
              n_nxt  = IDX_W'(sidx);
              dl_nxt = start;
              state_nxt = S_RST2;
            end
          end
          OP_QUERY: begin
            notice_nxt = 1'b0;
            state_nxt  = S_LAUNCH;
          end
          OP_EXPIRE: begin
            jump_nxt  = (prev_r > {16'b0, win_r}) &&
                        (in_ch.now_ms < prev_r - {16'b0, win_r});
            prev_nxt  = in_ch.now_ms;
            cnt_nxt   = '0;
            state_nxt = S_XMARK;
          end
          default: rs_nxt = ST_REJECT;
        endcase
      end
      S_RST2: begin
        cmd.op  = CC_SETDLPER;
        cmd.idx = n_r;
        cmd.dl  = sat_add48(dl_r, per_r);
        cmd.per = per_r;
        state_nxt = S_EMIT;
      end
      S_XMARK: begin
        cmd.op   = CC_MARK;
        cmd.jump = jump_r;
        cmd.now  = now_r;
        state_nxt = S_LAUNCH;
      end
      S_LAUNCH: state_nxt = S_WAIT;
      S_WAIT: if (res.go) begin
        case (op_r)
          OP_ADD: begin
            cmd.op  = CC_ADD;
            cmd.idx = n_r;
            cmd.dl  = dl_r;
            cmd.per = per_r;
            cmd.rec = rec_r;
            rslot_nxt = 4'(n_r);
            if (front && !notice_r) begin
              notice_nxt = 1'b1;
              rfront_nxt = 1'b1;
            end
            state_nxt = S_EMIT;
          end
          OP_QUERY: begin
            rrem_nxt = !res.found ? ALL_ONES48 :
                       (now_r >= res.dl) ? 48'd0 : res.dl - now_r;
            state_nxt = S_EMIT;
          end
          default: begin
            if (res.found) begin
              cmd.op  = CC_EXPIRE;
              cmd.idx = res.idx;
              cmd.dl  = sat_add48(now_r, per_w[res.idx[SW-1:0]]);
              list_nxt[cnt_r[EW-1:0]] = res.idx;
              cnt_nxt = cnt_r + 1'b1;
              e_nxt   = '0;
              state_nxt = (cnt_r == CW'(MAX_RESULTS - 1)) ? S_XEMIT : S_LAUNCH;
            end else if (cnt_r == '0) begin
              rs_nxt    = ST_REJECT;
              state_nxt = S_EMIT;
            end else begin
              e_nxt     = '0;
              state_nxt = S_XEMIT;
            end
          end
        endcase
      end
      S_EMIT: if (out_free) begin
        ov_nxt = 1'b1;
        os_nxt = rs_r; oslot_nxt = rslot_r; orem_nxt = rrem_r;
        ofront_nxt = rfront_r; opend_nxt = any_act; olast_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_XEMIT: if (out_free) begin
        ov_nxt = 1'b1;
        os_nxt = ST_DONE; oslot_nxt = 4'(list_r[e_r]); orem_nxt = '0;
        ofront_nxt = 1'b0; opend_nxt = any_act;
        olast_nxt = ({1'b0, e_r} + 1'b1 == (CW+1)'(cnt_r));
        if (olast_nxt) state_nxt = S_IDLE;
        else e_nxt = e_r + 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      notice_r <= 1'b0;
      prev_r   <= '0;
      win_r    <= WINDOW_RESET;
      ov_r     <= 1'b0;
      cnt_r    <= '0;
      e_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      notice_r <= notice_nxt;
      prev_r   <= prev_nxt;
      win_r    <= win_nxt;
      ov_r     <= ov_nxt;
      cnt_r    <= cnt_nxt;
      e_r      <= e_nxt;
    end
    op_r <= op_nxt; now_r <= now_nxt; per_r <= per_nxt; rec_r <= rec_nxt;
    n_r <= n_nxt; dl_r <= dl_nxt; jump_r <= jump_nxt;
    list_r <= list_nxt;
    rs_r <= rs_nxt; rslot_r <= rslot_nxt; rrem_r <= rrem_nxt; rfront_r <= rfront_nxt;
    os_r <= os_nxt; oslot_r <= oslot_nxt; orem_r <= orem_nxt;
    ofront_r <= ofront_nxt; opend_r <= opend_nxt; olast_r <= olast_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.status       = os_r;
  assign out_ch.slot_out     = oslot_r;
  assign out_ch.remaining_ms = orem_r;
  assign out_ch.front_notice = ofront_r;
  assign out_ch.any_pending  = opend_r;
  assign out_ch.last         = olast_r;
endmodule
